### design/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants
// Slot table sizing, request codes, beat structs and sequencer states for the
// deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int TIME_BITS = 48;
	localparam int IVL_W     = 32;

	typedef logic [TIME_BITS-1:0] tval_t;
	typedef logic [IVL_W-1:0]     ivl_t;
	typedef logic [SLOT_W-1:0]    sidx_t;

	localparam tval_t TMAX = '1;

	localparam logic [2:0] REQ_ADD     = 3'd0;
	localparam logic [2:0] REQ_CANCEL  = 3'd1;
	localparam logic [2:0] REQ_REFRESH = 3'd2;
	localparam logic [2:0] REQ_RESET   = 3'd3;
	localparam logic [2:0] REQ_EXPIRE  = 3'd4;
	localparam logic [2:0] REQ_QUERY   = 3'd5;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  timer_slot;
		logic [31:0] interval;
		logic        recurring;
		logic        count_now;
		logic [47:0] now;
	} dtq_req_t;

	typedef struct packed {
		logic [3:0]  result_slot;
		logic        ok;
		logic [47:0] delay;
		logic        front_hit;
		logic        last;
	} dtq_rsp_t;

	typedef struct packed {
		logic  act_we;
		logic  act_d;
		logic  dl_we;
		tval_t dl;
		logic  per_we;
		ivl_t  per;
		logic  rep;
	} slot_wr_t;

	typedef struct packed {
		logic  act;
		tval_t dl;
		ivl_t  per;
		logic  rep;
	} slot_rd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RSTADD,
		ST_FRONT,
		ST_QSCAN,
		ST_QEND,
		ST_ESCAN,
		ST_EEND,
		ST_OUT
	} dtq_state_t;

endpackage

`default_nettype wire

### design/dtq_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_slot_table: timer slot storage
// Active marks, deadlines, periods and repeat marks, one write and one read
// address per cycle. Active marks clear at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_slot_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dtq_pkg::sidx_t   rd_idx,
	output dtq_pkg::slot_rd_t     rd,
	output logic [dtq_pkg::SLOTS-1:0] active,
	input  wire dtq_pkg::sidx_t   wr_idx,
	input  wire dtq_pkg::slot_wr_t wr
);
	import dtq_pkg::*;

	logic [SLOTS-1:0] act_q;
	tval_t            dl_q  [SLOTS];
	ivl_t             per_q [SLOTS];
	logic             rep_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (wr.act_we) begin
			act_q[wr_idx] <= wr.act_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.dl_we) begin
			dl_q[wr_idx] <= wr.dl;
		end
		if (wr.per_we) begin
			per_q[wr_idx] <= wr.per;
			rep_q[wr_idx] <= wr.rep;
		end
	end

	assign active = act_q;
	assign rd.act = act_q[rd_idx];
	assign rd.dl  = dl_q[rd_idx];
	assign rd.per = per_q[rd_idx];
	assign rd.rep = rep_q[rd_idx];

endmodule

`default_nettype wire

### design/deadline_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue: sixteen-slot software timer table
// Request channel (req_valid/req_ready/req) takes add, cancel, refresh,
// reset, expire and next-delay query beats; response channel
// (rsp_valid/rsp_ready/rsp) returns one beat per result, the final one
// flagged by last. One request is worked at a time; req_ready is high only
// while the sequencer is idle.
// Cancel, refresh and unknown requests pass through the decode and output
// states before rsp_valid rises. Add walks all sixteen slots once through
// the single deadline comparator to decide front_hit; reset first writes
// the new deadline in its own state, then makes the same walk. A query
// walks the slots once to find the earliest deadline. Expire walks the
// slots once per emitted timer. req_ready returns the cycle after the final
// beat is loaded.
// The response register is freed as soon as its beat is taken; while the
// receiver stalls, the sequencer holds its next result and waits.
// Reset marks every slot free and clears the front-notify flag; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire dtq_pkg::dtq_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output dtq_pkg::dtq_rsp_t      rsp
);
	import dtq_pkg::*;

	function automatic tval_t sat_add(input tval_t a, input ivl_t b);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + (TIME_BITS+1)'(b);
		return sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
	endfunction

	dtq_state_t       state_q, state_d;
	dtq_req_t         req_q;
	sidx_t            idx_q, best_q, tgt_q;
	logic             best_vld_q, two_q, blocked_q, notified_q, more_q;
	tval_t            best_dl_q, tgt_dl_q, start_q;
	ivl_t             best_per_q;
	logic             best_rep_q;
	logic [SLOTS-1:0] picked_q;
	dtq_rsp_t         res_q, rsp_q;
	logic             rsp_valid_q;

	sidx_t            s_idx, rd_idx, wr_idx, free_idx;
	logic             s_ok, free_any, scan_last, out_load;
	logic             shortcut, blk_now, cand;
	slot_rd_t         rd;
	slot_wr_t         wr;
	logic [SLOTS-1:0] active;
	tval_t            now_t;

	dtq_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.active (active),
		.wr_idx (wr_idx),
		.wr     (wr)
	);

	assign now_t     = req_q.now;
	assign s_idx     = SLOT_W'(req_q.timer_slot);
	assign s_ok      = 32'(req_q.timer_slot) < SLOTS;
	assign scan_last = (idx_q == SLOT_W'(SLOTS-1));
	assign rd_idx    = (state_q == ST_DECODE || state_q == ST_RSTADD) ? s_idx : idx_q;
	assign shortcut  = !req_q.count_now && (req_q.interval == rd.per);

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS-1; i >= 0; i--) begin
			if (!active[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// Another active slot ahead of the target in deadline order.
	assign blk_now = rd.act && (idx_q != tgt_q) &&
		((rd.dl < tgt_dl_q) || ((rd.dl == tgt_dl_q) && (idx_q < tgt_q)));
	assign cand = rd.act && !picked_q[idx_q] && (rd.dl <= now_t);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (req_q.req_type)
					REQ_ADD:    state_d = free_any ? ST_FRONT : ST_OUT;
					REQ_RESET:  state_d = (s_ok && !shortcut && rd.act) ?
						ST_RSTADD : ST_OUT;
					REQ_EXPIRE: state_d = ST_ESCAN;
					REQ_QUERY:  state_d = ST_QSCAN;
					default:    state_d = ST_OUT;
				endcase
			end
			ST_RSTADD: state_d = ST_FRONT;
			ST_FRONT:  if (scan_last) state_d = ST_OUT;
			ST_QSCAN:  if (scan_last) state_d = ST_QEND;
			ST_QEND:   state_d = ST_OUT;
			ST_ESCAN:  if (scan_last) state_d = ST_EEND;
			ST_EEND:   state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = more_q ? ST_ESCAN : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs and table writes.
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		out_load  = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);
		wr        = '0;
		wr.per    = req_q.interval;
		wr.rep    = req_q.recurring;
		wr_idx    = s_idx;
		unique case (state_q)
			ST_DECODE: begin
				unique case (req_q.req_type)
					REQ_ADD: begin
						wr_idx    = free_idx;
						wr.act_we = free_any;
						wr.act_d  = 1'b1;
						wr.dl_we  = free_any;
						wr.dl     = sat_add(now_t, req_q.interval);
						wr.per_we = free_any;
					end
					REQ_CANCEL: begin
						wr.act_we = s_ok && rd.act;
						wr.act_d  = 1'b0;
					end
					REQ_REFRESH: begin
						wr.dl_we = s_ok && rd.act;
						wr.dl    = sat_add(now_t, rd.per);
					end
					default: ;
				endcase
			end
			ST_RSTADD: begin
				wr.dl_we  = 1'b1;
				wr.dl     = sat_add(start_q, req_q.interval);
				wr.per_we = 1'b1;
				wr.rep    = rd.rep;
			end
			ST_EEND: begin
				wr_idx    = best_q;
				wr.dl_we  = best_vld_q && best_rep_q;
				wr.dl     = sat_add(now_t, best_per_q);
				wr.act_we = best_vld_q && !best_rep_q;
				wr.act_d  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			notified_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end
			if (state_q == ST_DECODE && req_q.req_type == REQ_QUERY) begin
				notified_q <= 1'b0;
			end
			if (state_q == ST_FRONT && scan_last && !(blocked_q || blk_now)) begin
				notified_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req;
			end
			ST_DECODE: begin
				res_q      <= '{result_slot: '0, ok: 1'b0, delay: '0,
					front_hit: 1'b0, last: 1'b1};
				more_q     <= 1'b0;
				idx_q      <= '0;
				best_vld_q <= 1'b0;
				two_q      <= 1'b0;
				blocked_q  <= 1'b0;
				picked_q   <= '0;
				tgt_q      <= s_idx;
				unique case (req_q.req_type)
					REQ_ADD: begin
						tgt_q             <= free_idx;
						tgt_dl_q          <= sat_add(now_t, req_q.interval);
						res_q.ok          <= free_any;
						res_q.result_slot <= free_any ? 4'(free_idx) : 4'd0;
					end
					REQ_CANCEL, REQ_REFRESH: begin
						res_q.ok <= s_ok && rd.act;
					end
					REQ_RESET: begin
						res_q.ok <= s_ok && shortcut;
						if (req_q.count_now) begin
							start_q <= now_t;
						end else if (rd.dl >= TIME_BITS'(rd.per)) begin
							start_q <= rd.dl - TIME_BITS'(rd.per);
						end else begin
							start_q <= '0;
						end
					end
					default: ;
				endcase
			end
			ST_RSTADD: begin
				tgt_dl_q <= sat_add(start_q, req_q.interval);
				res_q.ok <= 1'b1;
			end
			ST_FRONT: begin
				if (blk_now) begin
					blocked_q <= 1'b1;
				end
				idx_q <= idx_q + 1'b1;
				res_q.front_hit <= !(blocked_q || blk_now) && !notified_q;
			end
			ST_QSCAN: begin
				if (rd.act && (!best_vld_q || rd.dl < best_dl_q)) begin
					best_vld_q <= 1'b1;
					best_dl_q  <= rd.dl;
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_QEND: begin
				res_q.ok <= 1'b1;
				if (!best_vld_q) begin
					res_q.delay <= '1;
				end else if (now_t >= best_dl_q) begin
					res_q.delay <= '0;
				end else begin
					res_q.delay <= 48'(best_dl_q - now_t);
				end
			end
			ST_ESCAN: begin
				if (cand) begin
					if (best_vld_q) begin
						two_q <= 1'b1;
					end
					if (!best_vld_q || rd.dl < best_dl_q) begin
						best_vld_q <= 1'b1;
						best_q     <= idx_q;
						best_dl_q  <= rd.dl;
						best_per_q <= rd.per;
						best_rep_q <= rd.rep;
					end
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_EEND: begin
				res_q.result_slot <= best_vld_q ? 4'(best_q) : 4'd0;
				res_q.ok          <= best_vld_q;
				res_q.last        <= !(best_vld_q && two_q);
				more_q            <= best_vld_q && two_q;
				if (best_vld_q) begin
					picked_q[best_q] <= 1'b1;
				end
				idx_q      <= '0;
				best_vld_q <= 1'b0;
				two_q      <= 1'b0;
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
